// ===== rtl/clean_first_lru_victim_select_assert.svh =====
// assertion macros for the clean-first lru victim select block
`ifndef CLEAN_FIRST_LRU_VICTIM_SELECT_ASSERT_SVH
`define CLEAN_FIRST_LRU_VICTIM_SELECT_ASSERT_SVH

// same-cycle implication, checked on clk and disabled in reset
`define CFLV_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk and disabled in reset
`define CFLV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cflv_pkg.sv =====
// shared types for the clean-first lru victim select block
package cflv_pkg;

  // command codes carried on the input tuser
  typedef enum logic [1:0] {
    CMD_TOUCH = 2'd0,
    CMD_INVAL = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  // control states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/cflv_ram.sv =====
// generic single-write, single-read ram with registered read data
module cflv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/clean_first_lru_victim_select.sv =====
// top level: clean-first lru replacement state and victim selection
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  s_tuser cmd, s_tdata set/way/dirty/time
//   m_*       out  m_tvalid/m_tready  m_tuser victim_valid, m_tdata victim_way
//
// one item at a time; the set row (all ways) lives in one ram, one read per item.
// touch and invalidate: transfer, write back, then result load.
// victim query: transfer, a scan with one way compared per cycle from the read row, then result load.
// unused command: transfer, then result load. after reset a clearing pass zeroes every set of the ram.
// a result waits in the output register while the next item is taken; if it is
// still not taken when the next result is ready, that item holds until it is.
`include "clean_first_lru_victim_select_assert.svh"

module clean_first_lru_victim_select #(
  parameter int NUM_SETS  = 64,
  parameter int NUM_WAYS  = 8,
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // set_index[5:0], way[8:6], dirty_mask[16:9], now_tick[48:17]
  input  logic [1:0]  s_tuser,  // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // victim_way[2:0]
  output logic        m_tuser   // victim_valid[0]
);

  localparam int AW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WW = $clog2(NUM_WAYS);
  localparam int RW = NUM_WAYS * TIME_BITS;

  cflv_pkg::state_t state, state_next;

  // item registers
  cflv_pkg::cmd_t item_cmd;
  logic [5:0]     item_set;
  logic [2:0]     item_way;
  logic [7:0]     item_dirty;
  logic [31:0]    item_now;

  logic [AW-1:0]  clr_cnt;
  logic           clr_done;
  logic [WW-1:0]  scan_idx;
  logic           scan_last;
  logic           scan_step;
  logic           take;

  logic             best_dirty;
  logic [TIME_BITS-1:0] best_time;
  logic [WW-1:0]    best_way;
  logic [WW+2:0]    best_ext;

  logic [NUM_WAYS-1:0]  dirty_ext;
  logic [TIME_BITS-1:0] cur_time;
  logic                 cur_dirty;
  logic [TIME_BITS-1:0] now_t;

  logic set_in_range;
  logic way_in_range;
  logic accept;
  logic out_free;
  logic out_load;

  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [RW-1:0] ram_wr_data;
  logic          ram_rd_en;
  logic [RW-1:0] ram_rd_data;
  logic [RW-1:0] row_upd;

  logic [2:0] m_victim;
  logic       m_valid;

  // replacement state: one row of timestamps per set
  cflv_ram #(
    .WIDTH (RW),
    .DEPTH (NUM_SETS)
  ) u_times (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (AW'(s_tdata[5:0])),
    .rd_data (ram_rd_data)
  );

  // dirty bits widened to the way count, missing ones read clean
  for (genvar g = 0; g < NUM_WAYS; g++) begin : g_dirty
    if (g < 8) begin : g_have
      assign dirty_ext[g] = item_dirty[g];
    end else begin : g_none
      assign dirty_ext[g] = 1'b0;
    end
  end

  // range checks and derived values
  assign set_in_range = (32'(item_set) < NUM_SETS);
  assign way_in_range = (32'(item_way) < NUM_WAYS);
  assign now_t        = TIME_BITS'(item_now);
  assign accept       = s_tvalid && s_tready;
  assign out_free     = !m_tvalid || m_tready;
  assign clr_done     = (clr_cnt == AW'(NUM_SETS - 1));
  assign scan_last    = (scan_idx == WW'(NUM_WAYS - 1));

  // one way of the read row per scan cycle
  assign cur_time  = ram_rd_data[scan_idx*TIME_BITS +: TIME_BITS];
  assign cur_dirty = dirty_ext[scan_idx];
  assign take      = (scan_idx == '0) || ({cur_dirty, cur_time} < {best_dirty, best_time});
  assign best_ext  = (WW + 3)'(best_way);

  // row with the addressed way replaced
  always_comb begin
    row_upd = ram_rd_data;
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (way_in_range && (32'(item_way) == i)) begin
        row_upd[i*TIME_BITS +: TIME_BITS] = (item_cmd == cflv_pkg::CMD_TOUCH) ? now_t : '0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cflv_pkg::ST_CLEAR: begin
        if (clr_done) state_next = cflv_pkg::ST_IDLE;
      end
      cflv_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          unique case (s_tuser)
            cflv_pkg::CMD_TOUCH, cflv_pkg::CMD_INVAL: state_next = cflv_pkg::ST_WRITE;
            cflv_pkg::CMD_QUERY:                      state_next = cflv_pkg::ST_SCAN;
            default:                                  state_next = cflv_pkg::ST_DONE;
          endcase
        end
      end
      cflv_pkg::ST_WRITE: state_next = cflv_pkg::ST_DONE;
      cflv_pkg::ST_SCAN: begin
        if (scan_last) state_next = cflv_pkg::ST_DONE;
      end
      cflv_pkg::ST_DONE: begin
        if (out_free) state_next = cflv_pkg::ST_IDLE;
      end
      default: state_next = cflv_pkg::ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready    = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = AW'(item_set);
    ram_wr_data = row_upd;
    scan_step   = 1'b0;
    out_load    = 1'b0;
    unique case (state)
      cflv_pkg::ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_cnt;
        ram_wr_data = '0;
      end
      cflv_pkg::ST_IDLE:  s_tready  = 1'b1;
      cflv_pkg::ST_WRITE: ram_wr_en = set_in_range && way_in_range;
      cflv_pkg::ST_SCAN:  scan_step = 1'b1;
      cflv_pkg::ST_DONE:  out_load  = out_free;
      default: ;
    endcase
  end

  assign ram_rd_en = accept;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cflv_pkg::ST_CLEAR;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == cflv_pkg::ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // item capture, scan and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd   <= cflv_pkg::cmd_t'(s_tuser);
      item_set   <= s_tdata[5:0];
      item_way   <= s_tdata[8:6];
      item_dirty <= s_tdata[16:9];
      item_now   <= s_tdata[48:17];
      scan_idx   <= '0;
    end else if (scan_step) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (scan_step && take) begin
      best_dirty <= cur_dirty;
      best_time  <= cur_time;
      best_way   <= scan_idx;
    end
    if (out_load) begin
      m_valid  <= (item_cmd == cflv_pkg::CMD_QUERY);
      m_victim <= ((item_cmd == cflv_pkg::CMD_QUERY) && set_in_range) ? best_ext[2:0] : 3'd0;
    end
  end

  assign m_tdata = {5'd0, m_victim};
  assign m_tuser = m_valid;

  // checks
  `CFLV_ASSERT_SAME(a_wr_state, ram_wr_en,
    (state == cflv_pkg::ST_CLEAR) || (state == cflv_pkg::ST_WRITE),
    "ram written outside clear or write back")
  `CFLV_ASSERT_NEXT(a_query_scan, accept && (s_tuser == cflv_pkg::CMD_QUERY),
    (state == cflv_pkg::ST_SCAN) && (scan_idx == '0),
    "query transfer did not start a scan at way zero")
  `CFLV_ASSERT_NEXT(a_scan_end, (state == cflv_pkg::ST_SCAN) && scan_last,
    state == cflv_pkg::ST_DONE, "scan did not end after the last way")
  `CFLV_ASSERT_NEXT(a_result_flag, out_load,
    m_tvalid && (m_tuser == $past(item_cmd == cflv_pkg::CMD_QUERY)),
    "result register load lost or flag wrong")
  `CFLV_ASSERT_NEXT(a_hold_done, (state == cflv_pkg::ST_DONE) && m_tvalid && !m_tready,
    state == cflv_pkg::ST_DONE, "finished item left while output register was full")

endmodule

// ===== tb/clean_first_lru_victim_select_tb.sv =====
// testbench for the clean-first lru victim select block: directed and random commands checked against a predictor
`timescale 1ns / 1ps

module clean_first_lru_victim_select_tb;

  localparam int          NUM_SETS    = 64;
  localparam int          NUM_WAYS    = 8;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          DRAIN_WAIT  = 2 * NUM_WAYS + 8;
  localparam int          HOLD_CYCLES = 400;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  // one replacement command as it goes onto the input stream
  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  set_idx;
    logic [2:0]  way_sel;
    logic [7:0]  dirty;
    logic [31:0] tick;
  } lru_op_t;

  // one victim answer
  typedef struct packed {
    logic [2:0] victim_way;
    logic       victim_valid;
  } victim_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;  // set_index[5:0], way[8:6], dirty_mask[16:9], now_tick[48:17]
  logic [1:0]  s_tuser = '0;  // cmd[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;       // victim_way[2:0]
  logic        m_tuser;       // victim_valid[0]

  lru_op_t     pending_ops[$];
  victim_t     expected_victims[$];
  logic [31:0] stamp_mem [NUM_SETS][NUM_WAYS];
  logic [31:0] tick_now = '0;
  int          cycle_count = 0;
  int          accepted_ops = 0;
  int          checked_ops = 0;
  int          total_ops = 0;
  int          mismatches = 0;
  int          send_gap = 0;
  int          ready_gap = 0;
  logic        hold_off = 1'b0;

  clean_first_lru_victim_select i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // idle length: mostly none, some short, a few long; long calm stretches without idling
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if ((cycle_count / 3000) % 3 == 2) return 0;
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // update the timestamp store and work out the answer of one command
  function automatic victim_t apply_lru_op(lru_op_t op);
    victim_t     res;
    logic [2:0]  best;
    logic        best_dirty;
    logic [31:0] best_stamp;
    res = '0;
    case (op.cmd)
      cflv_pkg::CMD_TOUCH: stamp_mem[op.set_idx][op.way_sel] = op.tick;
      cflv_pkg::CMD_INVAL: stamp_mem[op.set_idx][op.way_sel] = '0;
      cflv_pkg::CMD_QUERY: begin
        // clean beats dirty, then oldest stamp, then lowest way
        best       = '0;
        best_dirty = op.dirty[0];
        best_stamp = stamp_mem[op.set_idx][0];
        for (int w = 1; w < NUM_WAYS; w++) begin
          if (op.dirty[w] != best_dirty) begin
            if (!op.dirty[w]) begin
              best       = w[2:0];
              best_dirty = 1'b0;
              best_stamp = stamp_mem[op.set_idx][w];
            end
          end else if (stamp_mem[op.set_idx][w] < best_stamp) begin
            best       = w[2:0];
            best_stamp = stamp_mem[op.set_idx][w];
          end
        end
        res.victim_way   = best;
        res.victim_valid = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void queue_op(logic [1:0] cmd, logic [5:0] set_idx, logic [2:0] way_sel,
                                   logic [7:0] dirty, logic [31:0] tick);
    pending_ops.push_back({cmd, set_idx, way_sel, dirty, tick});
  endfunction

  // random command, mostly aimed at a few hot sets with a rising clock
  function automatic lru_op_t random_op();
    lru_op_t op;
    int      r;
    r = $urandom_range(0, 99);
    if (r < 45)      op.cmd = cflv_pkg::CMD_TOUCH;
    else if (r < 57) op.cmd = cflv_pkg::CMD_INVAL;
    else if (r < 95) op.cmd = cflv_pkg::CMD_QUERY;
    else             op.cmd = CMD_UNUSED;
    if ($urandom_range(0, 99) < 80) op.set_idx = 6'($urandom_range(0, 3) * 21);
    else                            op.set_idx = 6'($urandom);
    op.way_sel = 3'($urandom);
    r = $urandom_range(0, 99);
    if (r < 15)      op.dirty = 8'h00;
    else if (r < 25) op.dirty = 8'hff;
    else if (r < 40) op.dirty = ~(8'h01 << $urandom_range(0, 7));
    else             op.dirty = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 70) begin
      tick_now = tick_now + $urandom_range(0, 2);
      op.tick  = tick_now;
    end else if (r < 85) begin
      op.tick = $urandom;
    end else begin
      case ($urandom_range(0, 3))
        0:       op.tick = 32'h0000_0000;
        1:       op.tick = 32'h0000_0001;
        2:       op.tick = 32'hffff_ffff;
        default: op.tick = 32'hffff_fffe;
      endcase
    end
    return op;
  endfunction

  // sender: next command after the current transfer and its idle gap
  always @(posedge clk) begin
    lru_op_t op;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        op = pending_ops.pop_front();
        s_tdata  <= {7'd0, op.tick, op.dirty, op.way_sel, op.set_idx};
        s_tuser  <= op.cmd;
        s_tvalid <= 1'b1;
        send_gap <= idle_len();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stalls after transfers, plus the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap <= ready_gap - 1;
      m_tready  <= 1'b0;
    end else if (hold_off) begin
      m_tready <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      ready_gap <= idle_len();
      m_tready  <= 1'b1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // long hold-off on the result side once traffic is going
  initial begin
    while (accepted_ops < 400) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // predict on each input transfer, check each result transfer
  always @(posedge clk) begin
    victim_t exp_res;
    victim_t got_res;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got_res = {m_tdata[2:0], m_tuser};
        checked_ops++;
        if (expected_victims.size() == 0) begin
          $error("unexpected result: victim_way %0d victim_valid %0d",
                 got_res.victim_way, got_res.victim_valid);
          mismatches++;
        end else begin
          exp_res = expected_victims.pop_front();
          if (got_res.victim_way !== exp_res.victim_way) begin
            $error("victim_way: expected %0d, actual %0d",
                   exp_res.victim_way, got_res.victim_way);
            mismatches++;
          end
          if (got_res.victim_valid !== exp_res.victim_valid) begin
            $error("victim_valid: expected %0d, actual %0d",
                   exp_res.victim_valid, got_res.victim_valid);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        expected_victims.push_back(apply_lru_op({s_tuser, s_tdata[5:0], s_tdata[8:6],
                                                 s_tdata[16:9], s_tdata[48:17]}));
        accepted_ops++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("clean_first_lru_victim_select: mismatch");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin
    for (int s = 0; s < NUM_SETS; s++)
      for (int w = 0; w < NUM_WAYS; w++)
        stamp_mem[s][w] = '0;

    // queries on untouched sets: everything equally old
    queue_op(cflv_pkg::CMD_QUERY, 6'd0, 3'd5, 8'h00, 32'h1234_5678);
    queue_op(cflv_pkg::CMD_QUERY, 6'd63, 3'd2, 8'hff, 32'hffff_ffff);
    queue_op(cflv_pkg::CMD_QUERY, 6'd63, 3'd7, 8'h01, 32'h0);
    // extreme stamps and a tie between ways 1 and 2
    queue_op(cflv_pkg::CMD_TOUCH, 6'd5, 3'd0, 8'hff, 32'hffff_ffff);
    queue_op(cflv_pkg::CMD_TOUCH, 6'd5, 3'd1, 8'h00, 32'd7);
    queue_op(cflv_pkg::CMD_TOUCH, 6'd5, 3'd2, 8'haa, 32'd7);
    for (int w = 3; w < NUM_WAYS; w++)
      queue_op(cflv_pkg::CMD_TOUCH, 6'd5, 3'(w), 8'h55, 32'h8000_0000);
    queue_op(cflv_pkg::CMD_QUERY, 6'd5, 3'd0, 8'h00, 32'd0);
    queue_op(cflv_pkg::CMD_QUERY, 6'd5, 3'd0, 8'h02, 32'd0);
    // only one clean way left, then all dirty
    queue_op(cflv_pkg::CMD_QUERY, 6'd5, 3'd0, 8'h7f, 32'd0);
    queue_op(cflv_pkg::CMD_QUERY, 6'd5, 3'd0, 8'hff, 32'd0);
    // invalidate makes a way the oldest
    queue_op(cflv_pkg::CMD_INVAL, 6'd5, 3'd6, 8'hff, 32'hdead_beef);
    queue_op(cflv_pkg::CMD_QUERY, 6'd5, 3'd3, 8'h00, 32'd0);
    // unused command leaves state alone
    queue_op(CMD_UNUSED, 6'd5, 3'd1, 8'h00, 32'h0000_0000);
    queue_op(cflv_pkg::CMD_QUERY, 6'd5, 3'd0, 8'h40, 32'd0);
    queue_op(cflv_pkg::CMD_TOUCH, 6'd63, 3'd7, 8'h00, 32'h0);
    queue_op(cflv_pkg::CMD_INVAL, 6'd0, 3'd0, 8'hff, 32'hffff_ffff);
    queue_op(cflv_pkg::CMD_QUERY, 6'd5, 3'd0, 8'hbf, 32'd0);
    queue_op(cflv_pkg::CMD_QUERY, 6'd63, 3'd0, 8'h7f, 32'd0);

    for (int i = 0; i < 1530; i++)
      pending_ops.push_back(random_op());
    total_ops = pending_ops.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // every command answers once; wait until all answers have been checked
    while (checked_ops < total_ops)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("clean_first_lru_victim_select: match");
    end else begin
      $display("clean_first_lru_victim_select: mismatch");
    end
    $finish;
  end

endmodule
